FILE: rtl/u2b_pkg.sv
`default_nettype none

package u2b_pkg;

	// Replacement character for any invalid or unsupported sequence.
	localparam logic [15:0] QMARK = 16'h003F;

	// Kind of lead byte that is waiting for its continuation bytes.
	localparam logic [1:0] LEAD_NONE  = 2'd0;
	localparam logic [1:0] LEAD_TWO   = 2'd1;
	localparam logic [1:0] LEAD_THREE = 2'd2;
	localparam logic [1:0] LEAD_FOUR  = 2'd3;

	// Job queue between the classifier and the result sequencer.
	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	// One job describes all results of one input byte: q_count '?' marks,
	// then an optional decoded value. fin marks the end of the text.
	typedef struct packed {
		logic [2:0]  q_count;
		logic        has_val;
		logic [15:0] val;
		logic        fin;
	} job_t;

endpackage

`default_nettype wire

FILE: rtl/utf8_to_bmp_decoder_unit.sv
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------
// input    | push, full         | text_byte[7:0], final_byte
// result   | empty, pop         | code_point[15:0], run_last, text_last
//
// One byte is taken per cycle while full is low.
// A byte that yields n results holds the result sequencer for n pops.
// A four-entry job queue absorbs such bursts; full rises when it fills.
// Reset (arst_n low) clears any held sequence and empties the queue.
// A stalled result side holds the current result and fills the queue.

module utf8_to_bmp_decoder_unit (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        push,
	output logic              full,
	input  wire  logic [7:0]  text_byte,
	input  wire  logic        final_byte,
	output logic              empty,
	input  wire  logic        pop,
	output logic [15:0]       code_point,
	output logic              run_last,
	output logic              text_last
);

	u2b_pkg::job_t new_job;
	u2b_pkg::job_t head_job;
	logic          job_push;
	logic          head_pop;
	logic          queue_empty;

	// Classifier: tracks the pending sequence and describes each transaction.
	u2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.job_push   (job_push),
		.job        (new_job)
	);

	// Job queue that decouples the classifier from the sequencer.
	u2b_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (new_job),
		.pop      (head_pop),
		.head_job (head_job),
		.full     (full),
		.empty    (queue_empty)
	);

	// Sequencer: issues the results of each job in order.
	u2b_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (!queue_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.code_point (code_point),
		.run_last   (run_last),
		.text_last  (text_last)
	);

endmodule

`default_nettype wire

FILE: rtl/u2b_front.sv
`default_nettype none

module u2b_front (
	input  wire                logic        clk,
	input  wire                logic        arst_n,
	input  wire                logic        push,
	input  wire                logic        full,
	input  wire                logic [7:0]  text_byte,
	input  wire                logic        final_byte,
	output logic                            job_push,
	output u2b_pkg::job_t                   job
);

	logic [1:0]  lead_kind_q;
	logic [1:0]  held_count_q;
	logic [15:0] partial_q;

	logic [1:0]  lead_kind_d;
	logic [1:0]  held_count_d;
	logic [15:0] partial_d;

	logic        accept;
	logic        is_cont;
	logic [15:0] cont_val;
	logic [2:0]  held_plus;
	logic        complete;
	logic        seq_ok;

	assign accept    = push && !full;
	assign is_cont   = (text_byte[7:6] == 2'b10);
	assign cont_val  = {partial_q[9:0], text_byte[5:0]};
	assign held_plus = {1'b0, held_count_q} + 3'd1;
	assign complete  = (held_plus >= {1'b0, lead_kind_q});
	assign seq_ok    = (cont_val >= 16'h0800) && !(cont_val inside {[16'hD800:16'hDFFF]});

	// Classify the byte against the pending sequence and build its job.
	always_comb begin
		lead_kind_d  = lead_kind_q;
		held_count_d = held_count_q;
		partial_d    = partial_q;
		job.q_count  = 3'd0;
		job.has_val  = 1'b0;
		job.val      = u2b_pkg::QMARK;
		job.fin      = final_byte;
		if (lead_kind_q != u2b_pkg::LEAD_NONE && is_cont) begin
			if (complete) begin
				job.has_val = 1'b1;
				case (lead_kind_q)
					u2b_pkg::LEAD_TWO:   job.val = cont_val;
					u2b_pkg::LEAD_THREE: job.val = seq_ok ? cont_val : u2b_pkg::QMARK;
					default:             job.val = u2b_pkg::QMARK;
				endcase
				lead_kind_d  = u2b_pkg::LEAD_NONE;
				held_count_d = 2'd0;
				partial_d    = 16'd0;
			end else begin
				held_count_d = held_plus[1:0];
				partial_d    = cont_val;
				// End of text flushes the lead and every held continuation.
				if (final_byte) begin
					job.q_count  = held_plus + 3'd1;
					lead_kind_d  = u2b_pkg::LEAD_NONE;
					held_count_d = 2'd0;
					partial_d    = 16'd0;
				end
			end
		end else begin
			// A broken sequence gives one mark for each held byte.
			if (lead_kind_q != u2b_pkg::LEAD_NONE) begin
				job.q_count = held_plus;
			end
			lead_kind_d  = u2b_pkg::LEAD_NONE;
			held_count_d = 2'd0;
			partial_d    = 16'd0;
			if (text_byte < 8'h80) begin
				job.has_val = 1'b1;
				job.val     = {8'd0, text_byte};
			end else if (text_byte inside {[8'hC2:8'hDF]}) begin
				lead_kind_d = u2b_pkg::LEAD_TWO;
				partial_d   = {11'd0, text_byte[4:0]};
			end else if (text_byte inside {[8'hE0:8'hEF]}) begin
				lead_kind_d = u2b_pkg::LEAD_THREE;
				partial_d   = {12'd0, text_byte[3:0]};
			end else if (text_byte inside {[8'hF0:8'hF4]}) begin
				lead_kind_d = u2b_pkg::LEAD_FOUR;
			end else begin
				job.has_val = 1'b1;
				job.val     = u2b_pkg::QMARK;
			end
			// A new lead on the last byte of the text is flushed at once.
			if (final_byte && lead_kind_d != u2b_pkg::LEAD_NONE) begin
				job.q_count  = job.q_count + 3'd1;
				lead_kind_d  = u2b_pkg::LEAD_NONE;
				partial_d    = 16'd0;
			end
		end
	end

	assign job_push = accept && (job.q_count != 3'd0 || job.has_val);

	// Sequence state, updated on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_kind_q  <= u2b_pkg::LEAD_NONE;
			held_count_q <= 2'd0;
			partial_q    <= 16'd0;
		end else if (accept) begin
			lead_kind_q  <= lead_kind_d;
			held_count_q <= held_count_d;
			partial_q    <= partial_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/u2b_job_fifo.sv
`default_nettype none

module u2b_job_fifo (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic push,
	input  u2b_pkg::job_t            push_job,
	input  wire                logic pop,
	output u2b_pkg::job_t            head_job,
	output logic                     full,
	output logic                     empty
);

	u2b_pkg::job_t                       mem [u2b_pkg::JOB_DEPTH];
	logic [u2b_pkg::JOB_PTR_W-1:0]       wr_ptr_q;
	logic [u2b_pkg::JOB_PTR_W-1:0]       rd_ptr_q;
	logic [u2b_pkg::JOB_CNT_W-1:0]       count_q;

	assign full     = (count_q == u2b_pkg::JOB_CNT_W'(u2b_pkg::JOB_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/u2b_back.sv
`default_nettype none

module u2b_back (
	input  wire                logic        clk,
	input  wire                logic        arst_n,
	input  u2b_pkg::job_t                   head_job,
	input  wire                logic        head_valid,
	output logic                            head_pop,
	input  wire                logic        pop,
	output logic                            empty,
	output logic [15:0]                     code_point,
	output logic                            run_last,
	output logic                            text_last
);

	u2b_pkg::job_t cur_q;
	logic          cur_valid_q;
	logic          is_last;
	logic          take;

	// The current job ends when only the value, or only one mark, remains.
	assign is_last  = (cur_q.q_count == 3'd0) || (cur_q.q_count == 3'd1 && !cur_q.has_val);
	assign take     = pop && cur_valid_q;
	assign head_pop = head_valid && (!cur_valid_q || (take && is_last));

	assign empty      = !cur_valid_q;
	assign code_point = (cur_q.q_count != 3'd0) ? u2b_pkg::QMARK : cur_q.val;
	assign run_last   = is_last;
	assign text_last  = is_last && cur_q.fin;

	// Result sequencer: marks first, then the value, one per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
		end else if (head_pop) begin
			cur_valid_q <= 1'b1;
			cur_q       <= head_job;
		end else if (take) begin
			if (is_last) begin
				cur_valid_q <= 1'b0;
			end else begin
				cur_q.q_count <= cur_q.q_count - 3'd1;
			end
		end
	end

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_q.q_count != 3'd0 || cur_q.has_val))
		else $error("result job holds no result");
	a_idle_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !cur_valid_q) |=> cur_valid_q)
		else $error("waiting job not loaded into an idle sequencer");

endmodule

`default_nettype wire
